// ===== rtl/clkpr_pkg.sv =====
// Shared constants and the result beat type for the clock page replacement core.
// No dependencies; used by clkpr_seq, clock_page_replacement_core and clkpr_checker.
`default_nettype none

package clkpr_pkg;

    localparam int DEF_NUM_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 8;

    localparam int CFG_W     = 5;
    localparam int PAGE_W    = 8;
    localparam int SLOT_W    = 4;
    localparam int FAULT_W   = 16;
    localparam int MAX_IDX_W = 6;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [MAX_IDX_W-1:0] slot;
        logic                 ev_valid;
        logic [PAGE_W-1:0]    ev_page;
        logic [FAULT_W-1:0]   faults;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/clkpr_seq.sv =====
// Frame table, reference/valid bits, clock hand and fault counter with the
// sequencer that scans, sweeps and places one frame per cycle. Depends on clkpr_pkg.
`default_nettype none

module clkpr_seq #(
    parameter int  NUM_FRAMES = clkpr_pkg::DEF_NUM_FRAMES,
    parameter int  PAGE_BITS  = clkpr_pkg::DEF_PAGE_BITS,
    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start_accept,
    input  wire [clkpr_pkg::PAGE_W-1:0]   page,
    input  wire [IDX_W-1:0]               last_idx,
    output logic                          busy,
    output clkpr_pkg::res_t               res
);

    localparam int SW = (PAGE_BITS < clkpr_pkg::PAGE_W) ? PAGE_BITS : clkpr_pkg::PAGE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_PLACE = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [SW-1:0]                   pg_reg, pg_next;
    logic [IDX_W-1:0]                last_reg, last_next;
    logic [IDX_W-1:0]                scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]                hand_reg, hand_next;
    logic [NUM_FRAMES-1:0]           valid_reg, valid_next;
    logic [NUM_FRAMES-1:0]           ref_reg, ref_next;
    logic [clkpr_pkg::FAULT_W-1:0]   faults_reg, faults_next;

    logic [SW-1:0]                   mem [NUM_FRAMES];
    logic [SW-1:0]                   rd_data_reg;
    logic [IDX_W-1:0]                rd_addr;
    logic                            mem_we;
    logic                            match;
    logic [IDX_W-1:0]                hand_adv;

    assign busy     = (state_reg != ST_IDLE);
    assign rd_addr  = (state_reg == ST_SCAN) ? scan_idx_reg : hand_reg;
    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == pg_reg);
    assign hand_adv = (hand_reg == last_reg) ? '0 : hand_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        pg_next       = pg_reg;
        last_next     = last_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        hand_next     = hand_reg;
        valid_next    = valid_reg;
        ref_next      = ref_reg;
        faults_next   = faults_reg;
        mem_we        = 1'b0;
        res           = '0;
        res.faults    = faults_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_accept)
                begin
                    pg_next       = page[SW-1:0];
                    last_next     = last_idx;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_idx_next = scan_idx_reg;
                cmp_vld_next = 1'b1;
                if (scan_idx_reg != last_reg)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (match)
                begin
                    ref_next[cmp_idx_reg] = 1'b1;
                    res.done   = 1'b1;
                    res.hit    = 1'b1;
                    res.slot   = (clkpr_pkg::MAX_IDX_W)'(cmp_idx_reg);
                    state_next = ST_IDLE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == last_reg))
                begin
                    // restart the hand when the ring shrank below it
                    if (hand_reg > last_reg)
                    begin
                        hand_next = '0;
                    end
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_adv;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                mem_we               = 1'b1;
                valid_next[hand_reg] = 1'b1;
                ref_next[hand_reg]   = 1'b1;
                hand_next            = hand_adv;
                if (faults_reg != clkpr_pkg::FAULT_MAX)
                begin
                    faults_next = faults_reg + 1'b1;
                end
                res.done     = 1'b1;
                res.hit      = 1'b0;
                res.slot     = (clkpr_pkg::MAX_IDX_W)'(hand_reg);
                res.ev_valid = valid_reg[hand_reg];
                res.ev_page  = valid_reg[hand_reg] ? (clkpr_pkg::PAGE_W)'(rd_data_reg) : '0;
                res.faults   = faults_next;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            hand_reg     <= '0;
            valid_reg    <= '0;
            ref_reg      <= '0;
            faults_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_idx_reg  <= cmp_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            hand_reg     <= hand_next;
            valid_reg    <= valid_next;
            ref_reg      <= ref_next;
            faults_reg   <= faults_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pg_reg   <= pg_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[hand_reg] <= pg_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/clock_page_replacement_core.sv =====
// A hit is found by scanning the active frames in order; a fault scans all active
// frames, then sweeps past set reference bits and places the page at the hand.
// Throughput: one item at a time; busy stays high until the result beat.
// Reset clears the valid and reference bits, hand, fault count and sets num_frames to 16.
// The result beat lasts one cycle; the receiver cannot stall.
`default_nettype none

module clock_page_replacement_core #(
    parameter int NUM_FRAMES = clkpr_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = clkpr_pkg::DEF_PAGE_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [clkpr_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                              start,
    output logic                             busy,
    input  wire  [clkpr_pkg::PAGE_W-1:0]     page,
    output logic                             done,
    output logic                             hit,
    output logic [clkpr_pkg::SLOT_W-1:0]     slot,
    output logic                             evicted_valid,
    output logic [clkpr_pkg::PAGE_W-1:0]     evicted_page,
    output logic [clkpr_pkg::FAULT_W-1:0]    fault_count
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    logic [clkpr_pkg::CFG_W-1:0] num_frames_reg;
    logic [31:0]                 last_full;
    logic [31:0]                 slot_full;
    logic                        seq_busy;
    clkpr_pkg::res_t             res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg <= clkpr_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            num_frames_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (num_frames_reg == '0)
        begin
            last_full = 32'd0;
        end
        else if (32'(num_frames_reg) > 32'(NUM_FRAMES))
        begin
            last_full = 32'(NUM_FRAMES - 1);
        end
        else
        begin
            last_full = 32'(num_frames_reg) - 32'd1;
        end
    end

    clkpr_seq #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_accept (start && !seq_busy),
        .page         (page),
        .last_idx     (last_full[IDX_W-1:0]),
        .busy         (seq_busy),
        .res          (res)
    );

    assign busy      = seq_busy;
    assign slot_full = 32'(res.slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= res.done;
        end
    end

    // hold payload between beats
    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            hit           <= res.hit;
            slot          <= slot_full[clkpr_pkg::SLOT_W-1:0];
            evicted_valid <= res.ev_valid;
            evicted_page  <= res.ev_page;
            fault_count   <= res.faults;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clkpr_checker.sv =====
// Port-level checks for clock_page_replacement_core, attached by bind.
// Depends on clkpr_pkg and the top-level port list.
`default_nettype none

module clkpr_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              done,
    input wire                              hit,
    input wire                              evicted_valid,
    input wire [clkpr_pkg::PAGE_W-1:0]      evicted_page,
    input wire [clkpr_pkg::FAULT_W-1:0]     fault_count
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without work in progress");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && (evicted_page == '0)))
        else $error("hit reported an eviction");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (fault_count != '0))
        else $error("fault beat with zero fault count");

    a_empty_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted_valid) |-> (evicted_page == '0))
        else $error("evicted page nonzero without eviction");

endmodule

bind clock_page_replacement_core clkpr_checker u_clkpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
);

`default_nettype wire

// ===== tb/sv/clock_page_replacement_core_tb.sv =====
// Self-checking testbench for clock_page_replacement_core: drives page references and
// frame-count writes, mirrors the clock table in a scoreboard class and checks every beat.
// Depends on clkpr_pkg and the core RTL only.
module clock_page_replacement_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clkpr_pkg::*;

    localparam int FRAMES       = DEF_NUM_FRAMES;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASES       = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [FAULT_W-1:0] faults;
    } outcome_t;

    class frame_table_mirror;
        logic [PAGE_W-1:0]  frame_page [FRAMES];
        bit                 frame_valid [FRAMES];
        bit                 ref_bit [FRAMES];
        int unsigned        hand;
        logic [FAULT_W-1:0] faults;
        logic [CFG_W-1:0]   frames_reg;
        outcome_t           awaited [$];
        int unsigned        mismatches;

        function new();
            foreach (frame_page[i])
            begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                ref_bit[i]     = 1'b0;
            end
            hand       = 0;
            faults     = '0;
            frames_reg = CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_reg = value;
        endfunction

        function int unsigned active_frames();
            if (frames_reg == 0)
                return 1;
            if (frames_reg > FRAMES)
                return FRAMES;
            return 32'(frames_reg);
        endfunction

        function int unsigned next_frame(int unsigned idx, int unsigned n);
            return (idx + 1 >= n) ? 0 : idx + 1;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] pg);
            int unsigned n;
            int unsigned steps;
            outcome_t    o;
            n = active_frames();
            o = '0;
            for (int i = 0; i < n; i++)
            begin
                if (!o.hit && frame_valid[i] && frame_page[i] == pg)
                begin
                    o.hit      = 1'b1;
                    o.slot     = SLOT_W'(i);
                    ref_bit[i] = 1'b1;
                end
            end
            if (!o.hit)
            begin
                steps = 0;
                if (hand >= n)
                    hand = 0;
                while (ref_bit[hand] && steps <= n)
                begin
                    ref_bit[hand] = 1'b0;
                    hand = next_frame(hand, n);
                    steps++;
                end
                o.slot = SLOT_W'(hand);
                if (frame_valid[hand])
                begin
                    o.ev_valid = 1'b1;
                    o.ev_page  = frame_page[hand];
                end
                frame_page[hand]  = pg;
                frame_valid[hand] = 1'b1;
                ref_bit[hand]     = 1'b1;
                hand = next_frame(hand, n);
                if (faults != FAULT_MAX)
                    faults++;
            end
            o.faults = faults;
            awaited.push_back(o);
        endfunction

        function void report(string what, outcome_t exp, outcome_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("%0t: %s exp hit=%0b slot=%0d evv=%0b evp=%02h fc=%0d",
                         $realtime, what, exp.hit, exp.slot, exp.ev_valid, exp.ev_page,
                         exp.faults);
                $display("%0t: %s got hit=%0b slot=%0d evv=%0b evp=%02h fc=%0d",
                         $realtime, what, got.hit, got.slot, got.ev_valid, got.ev_page,
                         got.faults);
            end
        endfunction

        function void check_beat(outcome_t got);
            outcome_t exp;
            if (awaited.size() == 0)
            begin
                report("unexpected beat", '0, got);
                return;
            end
            exp = awaited.pop_front();
            if (got.hit !== exp.hit || got.slot !== exp.slot || got.ev_valid !== exp.ev_valid
                || got.ev_page !== exp.ev_page || got.faults !== exp.faults)
                report("mismatch", exp, got);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               start     = 1'b0;
    logic [PAGE_W-1:0]  page      = '0;
    logic               busy;
    logic               done;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
    int unsigned        cycle_count;

    frame_table_mirror table_mirror = new();

    clock_page_replacement_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .done          (done),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            table_mirror.check_beat(outcome_t'({hit, slot, evicted_valid, evicted_page,
                                                fault_count}));
    end

    task automatic send_page(input logic [PAGE_W-1:0] pg, input int unsigned idle_pct);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            page  <= pg;
            do
                @(posedge clk);
            while (busy);
            table_mirror.note_reference(pg);
        end
    endtask

    task automatic hold_until_drained();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (table_mirror.awaited.size() != 0 || busy)
                @(posedge clk);
        end
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        begin
            hold_until_drained();
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
            table_mirror.set_frames(value);
        end
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(int unsigned base, int unsigned spread);
        if ($urandom_range(3) == 0)
            return PAGE_W'($urandom_range(255));
        return PAGE_W'((base + $urandom_range(spread)) % 256);
    endfunction

    initial
    begin
        int unsigned      frame_sweep [6] = '{1, 16, 0, 31, 2, 17};
        int unsigned      idle_plan [4]   = '{0, 75, 0, 7};
        int unsigned      idle_pct;
        int unsigned      base;
        int unsigned      spread;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill empty frames, then hit on them
        send_page(8'h00, 0);
        send_page(8'hFF, 0);
        send_page(8'h00, 0);
        send_page(8'hFF, 0);
        send_page(8'hA5, 0);
        // shrink below the hand: sweep, then evict
        write_frames(5'd2);
        send_page(8'h5A, 0);
        send_page(8'hFF, 0);
        send_page(8'hC3, 0);
        send_page(8'h3C, 0);
        // zero frames acts as one
        write_frames(5'd0);
        send_page(8'h11, 0);
        send_page(8'h22, 0);
        send_page(8'h22, 0);
        // oversized count clamps to the table size
        write_frames(5'd31);
        send_page(8'hA5, 0);
        send_page(8'h80, 0);
        send_page(8'h01, 0);
        send_page(8'h7F, 0);
        write_frames(5'd17);
        send_page(8'h80, 0);
        send_page(8'h40, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_frames(CFG_W'(ph < 6 ? frame_sweep[ph] : $urandom_range(31)));
            idle_pct = idle_plan[ph % 4];
            base     = $urandom_range(255);
            spread   = $urandom_range(1, 24);
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                send_page(pick_page(base, spread), idle_pct);
                if ($urandom_range(49) == 0)
                    hold_until_drained();
            end
        end

        write_frames(5'd16);
        base = $urandom_range(255);
        repeat (40)
            send_page(pick_page(base, 20), 75);

        hold_until_drained();
        repeat (50) @(posedge clk);
        if (table_mirror.mismatches == 0 && table_mirror.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/clkpr_pkg.sv
rtl/clkpr_seq.sv
rtl/clock_page_replacement_core.sv
rtl/clkpr_checker.sv
tb/sv/clock_page_replacement_core_tb.sv
